// ===== src/iol_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iol_pkg
// Types and constants shared by the indexed ordered list controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package iol_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STAT_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND   = 3'd0,
    REQ_INSERT   = 3'd1,
    REQ_REMOVE   = 3'd2,
    REQ_READ     = 3'd3,
    REQ_WRITE    = 3'd4,
    REQ_POP_AT   = 3'd5,
    REQ_POP_LAST = 3'd6
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RA_IDX,
    RA_LAST,
    RA_NEXT
  } rd_sel_e;

  typedef enum logic [1:0] {
    WA_TAIL,
    WA_IDX,
    WA_PTR
  } wr_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic    load_in;
    logic    chk;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    ptr_init;
    logic    ptr_step;
    logic    grab;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    req_e    req;
    status_e err;
    logic    more;
    logic    out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/iol_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iol_datapath
// Entry memory, request registers, length counter, shift pointer and
// output register of the indexed ordered list.
// ----------------------------------------------------------------------------
module iol_datapath
  import iol_pkg::*;
(
  input  wire  logic                     clk_i,
  input  wire  logic                     rst_ni,
  input  wire  cmd_t                     cmd_i,
  output dp_stat_t                       stat_o,
  input  wire  logic [REQ_W-1:0]         req_type_i,
  input  wire  logic [IDX_W-1:0]         index_i,
  input  wire  logic signed [DATA_W-1:0] value_i,
  output logic                           out_valid_o,
  input  wire  logic                     out_ready_i,
  output logic signed [DATA_W-1:0]       data_o,
  output logic [CNT_W-1:0]               length_o,
  output logic [STAT_W-1:0]              status_o
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_q;

  req_e              req_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [DATA_W-1:0] res_q, res_d;
  status_e           stat_q;
  status_e           err;

  logic              up;
  logic [CNT_W-1:0]  nbr;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              out_valid_q;
  logic signed [DATA_W-1:0] data_q;
  logic [CNT_W-1:0]  length_q;
  logic [STAT_W-1:0] status_q;

  assign up  = (req_q == REQ_INSERT);
  assign nbr = up ? (ptr_q - CNT_W'(1)) : (ptr_q + CNT_W'(1));

  always_comb begin
    err = ST_OK;
    case (req_q)
      REQ_APPEND: begin
        if (count_q >= CNT_W'(CAPACITY)) err = ST_FULL;
      end
      REQ_INSERT: begin
        if ({1'b0, idx_q} > {1'b0, count_q}) err = ST_RANGE;
        else if (count_q >= CNT_W'(CAPACITY)) err = ST_FULL;
      end
      REQ_REMOVE, REQ_READ, REQ_WRITE, REQ_POP_AT: begin
        if ({1'b0, idx_q} >= {1'b0, count_q}) err = ST_RANGE;
      end
      REQ_POP_LAST: begin
        if (count_q == '0) err = ST_RANGE;
      end
      default: err = ST_OK;
    endcase
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RA_IDX:  rd_addr = idx_q[ADDR_W-1:0];
      RA_LAST: rd_addr = ADDR_W'(count_q - CNT_W'(1));
      RA_NEXT: rd_addr = nbr[ADDR_W-1:0];
      default: rd_addr = idx_q[ADDR_W-1:0];
    endcase
    case (cmd_i.wr_sel)
      WA_TAIL: begin
        wr_addr = count_q[ADDR_W-1:0];
        wr_data = val_q;
      end
      WA_IDX: begin
        wr_addr = idx_q[ADDR_W-1:0];
        wr_data = val_q;
      end
      WA_PTR: begin
        wr_addr = ptr_q[ADDR_W-1:0];
        wr_data = rd_data_q;
      end
      default: begin
        wr_addr = idx_q[ADDR_W-1:0];
        wr_data = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) count_d = count_q + CNT_W'(1);
    else if (cmd_i.cnt_dec) count_d = count_q - CNT_W'(1);

    ptr_d = ptr_q;
    if (cmd_i.ptr_init) ptr_d = up ? count_q : CNT_W'(idx_q);
    else if (cmd_i.ptr_step) ptr_d = nbr;

    res_d = res_q;
    if (cmd_i.load_in) res_d = '0;
    else if (cmd_i.grab) res_d = rd_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q <= req_e'(req_type_i);
      idx_q <= index_i;
      val_q <= value_i;
    end
    if (cmd_i.chk) stat_q <= err;
    ptr_q <= ptr_d;
    res_q <= res_d;
    if (cmd_i.out_load) begin
      data_q   <= res_q;
      length_q <= count_q;
      status_q <= stat_q;
    end
  end

  assign stat_o.req      = req_q;
  assign stat_o.err      = err;
  assign stat_o.more     = up ? (ptr_q > CNT_W'(idx_q)) : ((ptr_q + CNT_W'(1)) < count_q);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign data_o      = data_q;
  assign length_o    = length_q;
  assign status_o    = status_q;

endmodule
`default_nettype wire

// ===== src/iol_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iol_ctrl
// Request sequencer: checks the request, steps the entry shift one entry
// per read/write pair, and hands the result to the output register.
// ----------------------------------------------------------------------------
module iol_ctrl
  import iol_pkg::*;
(
  input  wire  logic     clk_i,
  input  wire  logic     rst_ni,
  input  wire  logic     in_valid_i,
  output logic           in_ready_o,
  input  wire  dp_stat_t stat_i,
  output cmd_t           cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.chk = 1'b1;
        if (stat_i.err != ST_OK) begin
          state_d = S_DONE;
        end else begin
          case (stat_i.req)
            REQ_APPEND: begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = WA_TAIL;
              cmd_o.cnt_inc = 1'b1;
              state_d       = S_DONE;
            end
            REQ_WRITE: begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = WA_IDX;
              state_d      = S_DONE;
            end
            REQ_READ, REQ_POP_AT: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_IDX;
              state_d      = S_FETCH;
            end
            REQ_POP_LAST: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_LAST;
              state_d      = S_FETCH;
            end
            REQ_INSERT, REQ_REMOVE: begin
              cmd_o.ptr_init = 1'b1;
              state_d        = S_SHIFT_RD;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_FETCH: begin
        cmd_o.grab = 1'b1;
        case (stat_i.req)
          REQ_POP_LAST: begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_DONE;
          end
          REQ_POP_AT: begin
            cmd_o.ptr_init = 1'b1;
            state_d        = S_SHIFT_RD;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SHIFT_RD: begin
        if (stat_i.more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_NEXT;
          state_d      = S_SHIFT_WR;
        end else if (stat_i.req == REQ_INSERT) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WA_IDX;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WA_PTR;
        cmd_o.ptr_step = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/indexed_ordered_list_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_ordered_list_unit
// Ordered list of up to 64 signed 32-bit entries with indexed access.
// Input channel (in_valid_i/in_ready_o) carries req_type, index, value;
// output channel (out_valid_o/out_ready_i) returns data, length, status,
// one result transfer per request transfer, in order.
// Requests run one at a time. Append, write, unknown and rejected requests
// go from decode straight to done; read and pop last pass through a fetch;
// insert and remove step the entry shift, and pop at index fetches and then
// shifts. Each moved entry takes a read (S_SHIFT_RD) and then a write
// (S_SHIFT_WR), since the read data is registered before it is written back.
// The next request is taken in the cycle after a result loads.
// A new request is taken once the previous result sits in the output
// register, even if the receiver has not taken it yet; if the receiver
// stalls, the next result waits in the sequencer until the register frees.
// Reset empties the list (length zero) and drops any pending result;
// entry memory contents are not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_ordered_list_unit
  import iol_pkg::*;
(
  input  wire  logic                     clk_i,
  input  wire  logic                     rst_ni,
  input  wire  logic                     in_valid_i,
  output logic                           in_ready_o,
  input  wire  logic [REQ_W-1:0]         req_type_i,
  input  wire  logic [IDX_W-1:0]         index_i,
  input  wire  logic signed [DATA_W-1:0] value_i,
  output logic                           out_valid_o,
  input  wire  logic                     out_ready_i,
  output logic signed [DATA_W-1:0]       data_o,
  output logic [CNT_W-1:0]               length_o,
  output logic [STAT_W-1:0]              status_o
);

  cmd_t     cmd;
  dp_stat_t stat;

  iol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  iol_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_type_i  (req_type_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (data_o),
    .length_o    (length_o),
    .status_o    (status_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for indexed_ordered_list_unit. A shadow list follows
// every request transfer and predicts data, length and status. A monitor
// checks each result transfer in order against that prediction. Directed
// tests cover the empty list, bad indexes, head and tail inserts, value
// extremes and the full list. Random phases grow and drain the list with
// stall bursts on both channels, and a final phase runs with no stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import iol_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS   = 160;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_NEG = -32'sd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         length;
    logic [STAT_W-1:0]        status;
  } list_result_t;

  typedef enum int { MIX_GROW, MIX_SHRINK, MIX_BALANCED } op_mix_e;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [REQ_W-1:0]         req_type_i = '0;
  logic [IDX_W-1:0]         index_i    = '0;
  logic signed [DATA_W-1:0] value_i    = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] data_o;
  logic [CNT_W-1:0]         length_o;
  logic [STAT_W-1:0]        status_o;

  logic signed [DATA_W-1:0] shadow_list [CAPACITY];
  int unsigned              shadow_len = 0;
  list_result_t             pending_results [$];
  bit                       stalls_on = 1'b1;
  int unsigned              error_cnt = 0;
  int unsigned              quiet_cycles = 0;

  indexed_ordered_list_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (data_o),
    .length_o    (length_o),
    .status_o    (status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow list: open a gap at pos and place val there.
  function automatic void shadow_insert(int unsigned pos, logic signed [DATA_W-1:0] val);
    for (int unsigned i = shadow_len; i > pos; i--) begin
      shadow_list[i] = shadow_list[i-1];
    end
    shadow_list[pos] = val;
    shadow_len++;
  endfunction

  // Shadow list: take out the entry at pos and close the gap.
  function automatic logic signed [DATA_W-1:0] shadow_take(int unsigned pos);
    logic signed [DATA_W-1:0] val;
    val = shadow_list[pos];
    for (int unsigned i = pos; i + 1 < shadow_len; i++) begin
      shadow_list[i] = shadow_list[i+1];
    end
    shadow_len--;
    return val;
  endfunction

  function automatic list_result_t list_apply(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                              logic signed [DATA_W-1:0] val);
    list_result_t res;
    res.data   = '0;
    res.status = ST_OK;
    case (req)
      REQ_APPEND: begin
        if (shadow_len >= CAPACITY) res.status = ST_FULL;
        else shadow_insert(shadow_len, val);
      end
      REQ_INSERT: begin
        if (idx > shadow_len) res.status = ST_RANGE;
        else if (shadow_len >= CAPACITY) res.status = ST_FULL;
        else shadow_insert(idx, val);
      end
      REQ_REMOVE: begin
        if (idx >= shadow_len) res.status = ST_RANGE;
        else void'(shadow_take(idx));
      end
      REQ_READ: begin
        if (idx >= shadow_len) res.status = ST_RANGE;
        else res.data = shadow_list[idx];
      end
      REQ_WRITE: begin
        if (idx >= shadow_len) res.status = ST_RANGE;
        else shadow_list[idx] = val;
      end
      REQ_POP_AT: begin
        if (idx >= shadow_len) res.status = ST_RANGE;
        else res.data = shadow_take(idx);
      end
      REQ_POP_LAST: begin
        if (shadow_len == 0) res.status = ST_RANGE;
        else res.data = shadow_take(shadow_len - 1);
      end
      default: ;
    endcase
    res.length = shadow_len[CNT_W-1:0];
    return res;
  endfunction

  task automatic send_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                              logic signed [DATA_W-1:0] val);
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    index_i    <= idx;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(list_apply(req, idx, val));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(op_mix_e mix);
    logic [REQ_W-1:0]         codes [8];
    int unsigned              weights [8];
    logic [REQ_W-1:0]         req;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] val;
    int unsigned              roll;
    codes = '{REQ_APPEND, REQ_INSERT, REQ_REMOVE, REQ_READ, REQ_WRITE, REQ_POP_AT,
              REQ_POP_LAST, REQ_UNKNOWN};
    case (mix)
      MIX_GROW:   weights = '{30, 25, 8, 10, 8, 8, 6, 5};
      MIX_SHRINK: weights = '{6, 6, 25, 10, 8, 25, 15, 5};
      default:    weights = '{14, 14, 14, 14, 14, 14, 11, 5};
    endcase
    roll = $urandom_range(0, 99);
    req  = REQ_UNKNOWN;
    for (int k = 0; k < 8; k++) begin
      if (roll < weights[k]) begin
        req = codes[k];
        break;
      end
      roll -= weights[k];
    end
    roll = $urandom_range(0, 9);
    if (roll < 6) idx = IDX_W'($urandom_range(0, shadow_len));
    else if (roll == 6) idx = IDX_W'(shadow_len - $urandom_range(0, 1));
    else if (roll == 7) idx = IDX_W'(shadow_len + 1);
    else idx = IDX_W'($urandom());
    case ($urandom_range(0, 15))
      0:       val = VAL_MIN;
      1:       val = VAL_MAX;
      2:       val = '0;
      3:       val = VAL_NEG;
      default: val = $urandom();
    endcase
    send_request(req, idx, val);
  endtask

  task automatic test_empty_list();
    send_request(REQ_POP_LAST, '0, '0);
    send_request(REQ_READ, '0, '0);
    send_request(REQ_REMOVE, '0, '0);
    send_request(REQ_WRITE, '0, VAL_NEG);
    send_request(REQ_POP_AT, '0, '0);
    send_request(REQ_INSERT, 7'd1, VAL_MAX);
    send_request(REQ_UNKNOWN, '0, VAL_MIN);
    send_request(REQ_INSERT, '0, VAL_MAX);
    send_request(REQ_REMOVE, '0, '0);
    send_request(REQ_APPEND, '0, VAL_MIN);
    send_request(REQ_APPEND, '0, VAL_MAX);
    send_request(REQ_APPEND, '0, '0);
    send_request(REQ_APPEND, '0, VAL_NEG);
    send_request(REQ_INSERT, '0, 32'sd5);
    send_request(REQ_INSERT, 7'd5, 32'sd6);
    send_request(REQ_INSERT, 7'd7, 32'sd7);
    send_request(REQ_READ, '0, '0);
    send_request(REQ_READ, 7'd5, '0);
    send_request(REQ_READ, 7'd6, '0);
    send_request(REQ_READ, 7'h7F, '0);
    send_request(REQ_WRITE, 7'd3, 32'sh5A5A_A5A5);
    send_request(REQ_READ, 7'd3, '0);
    send_request(REQ_POP_AT, '0, '0);
    send_request(REQ_POP_LAST, 7'h7F, '0);
    send_request(REQ_REMOVE, 7'd1, '0);
    send_request(REQ_UNKNOWN, 7'h7F, VAL_NEG);
  endtask

  task automatic test_full_list();
    while (shadow_len < CAPACITY) send_request(REQ_APPEND, IDX_W'($urandom()), $urandom());
    send_request(REQ_APPEND, '0, VAL_MAX);
    send_request(REQ_INSERT, '0, VAL_MAX);
    send_request(REQ_INSERT, IDX_W'(CAPACITY), VAL_MIN);
    send_request(REQ_INSERT, IDX_W'(CAPACITY + 1), VAL_MIN);
    send_request(REQ_READ, IDX_W'(CAPACITY - 1), '0);
    send_request(REQ_READ, IDX_W'(CAPACITY), '0);
    send_request(REQ_WRITE, IDX_W'(CAPACITY - 1), VAL_MIN);
    send_request(REQ_POP_AT, '0, '0);
    send_request(REQ_INSERT, '0, VAL_NEG);
    send_request(REQ_REMOVE, '0, '0);
    send_request(REQ_READ, IDX_W'(CAPACITY - 2), '0);
    while (shadow_len > 0) send_request(REQ_POP_LAST, IDX_W'($urandom()), $urandom());
    send_request(REQ_POP_LAST, '0, '0);
  endtask

  task automatic test_random_phases();
    op_mix_e mix;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0:       mix = MIX_GROW;
        1:       mix = MIX_SHRINK;
        default: mix = MIX_BALANCED;
      endcase
      repeat (PHASE_ITEMS) send_random(mix);
      if (phase == 2) wait_drained();
    end
  endtask

  task automatic test_no_stalls();
    stalls_on = 1'b0;
    repeat (60) send_random(MIX_GROW);
    repeat (90) send_random(MIX_BALANCED);
  endtask

  // Result side: random stall bursts while enabled.
  initial begin
    forever begin
      if (stalls_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        error_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (data_o !== exp_res.data) begin
          $error("data mismatch: expected %0d, actual %0d", exp_res.data, data_o);
          error_cnt++;
        end
        if (length_o !== exp_res.length) begin
          $error("length mismatch: expected %0d, actual %0d", exp_res.length, length_o);
          error_cnt++;
        end
        if (status_o !== exp_res.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_res.status, status_o);
          error_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    wait_drained();
    test_full_list();
    wait_drained();
    test_random_phases();
    test_no_stalls();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/iol_pkg.sv
src/iol_datapath.sv
src/iol_ctrl.sv
src/indexed_ordered_list_unit.sv
tb/sv/tb_top.sv
